[hdl/ldq_pkg.sv]
// ----------------------------------------------------------------------------
// ldq_pkg
// Shared types and codes for the leveled ready deque.
// ----------------------------------------------------------------------------
package ldq_pkg;

    localparam int LEVELS_DEF = 16;
    localparam int SLOTS_DEF  = 64;

    localparam logic [1:0] REQ_POST  = 2'd0;
    localparam logic [1:0] REQ_TAKE  = 2'd1;
    localparam logic [1:0] REQ_STEAL = 2'd2;
    localparam logic [1:0] REQ_NONE  = 2'd3;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_EMPTY     = 2'd1;
    localparam logic [1:0] ST_FULL      = 2'd2;
    localparam logic [1:0] ST_OUT_RANGE = 2'd3;

    typedef struct packed {
        logic [1:0]  req_type;
        logic [15:0] task_handle;
        logic [7:0]  target_level;
    } t_req_item;

    typedef struct packed {
        logic [1:0]  status;
        logic [15:0] handle_out;
        logic [3:0]  level_used;
    } t_rsp_item;

    typedef enum logic [1:0] {
        S_IDLE,
        S_LOOK,
        S_READ,
        S_HOLD
    } t_state;

endpackage

[hdl/leveled_ready_deque_top.sv]
// ----------------------------------------------------------------------------
// leveled_ready_deque_top
// Leveled task ready queue: post to a level head, take the deepest head,
// steal the shallowest tail.
//
//   channel  direction  handshake                payload
//   request  in         i_in_valid / o_in_ready  i_in  (t_req_item)
//   result   out        o_out_valid / i_out_ready o_out (t_rsp_item)
//
// When results drain, a request runs as level pick and level table read,
// then table update with slot read or write; the next request enters
// in the cycle the result is loaded. The two registered memory reads set this order.
// Reset clears the level table valid bits; no clearing pass.
// A stalled result holds the block in its final state; one result register.
// ----------------------------------------------------------------------------
module leveled_ready_deque_top import ldq_pkg::*; #(
    parameter int LEVELS = LEVELS_DEF,
    parameter int SLOTS  = SLOTS_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_req_item i_in,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_rsp_item o_out
);

    localparam int LW = $clog2(LEVELS);
    localparam int HW = $clog2(SLOTS);
    localparam int CW = $clog2(SLOTS + 1);
    localparam int AW = $clog2(LEVELS * SLOTS);

    t_state r_state, n_state;

    logic              w_load, w_acc;
    logic [LEVELS-1:0] w_nonempty;
    logic [LW-1:0]     w_deep, w_shallow, w_pick;
    logic              w_any;

    logic [1:0]    r_kind;
    logic [15:0]   r_handle;
    logic          r_bad;
    logic          r_empty;
    logic [LW-1:0] r_lvl;

    logic [1:0]    r_status, n_status;
    logic [LW-1:0] r_lvl_res, n_lvl_res;
    logic          r_pop, n_pop;

    logic [HW-1:0] w_head;
    logic [CW-1:0] w_count;
    logic          w_tab_wr;
    logic [HW-1:0] w_new_head;
    logic [CW-1:0] w_new_count;
    logic          w_slot_wr, w_slot_rd;
    logic [HW-1:0] w_pos;
    logic [HW:0]   w_tail_sum;
    logic [AW-1:0] w_slot_addr;
    logic [15:0]   w_slot_rdata;

    logic      r_out_valid;
    t_rsp_item r_out;

    ldq_level_pick #(.LEVELS(LEVELS), .LW(LW)) u_pick (
        .i_nonempty (w_nonempty),
        .o_deep     (w_deep),
        .o_shallow  (w_shallow),
        .o_any      (w_any)
    );

    ldq_level_table #(
        .LEVELS(LEVELS), .SLOTS(SLOTS), .LW(LW), .HW(HW), .CW(CW)
    ) u_table (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_rd_en    (w_acc),
        .i_rd_addr  (w_pick),
        .o_rd_head  (w_head),
        .o_rd_count (w_count),
        .i_wr_en    (w_tab_wr),
        .i_wr_addr  (r_lvl),
        .i_wr_head  (w_new_head),
        .i_wr_count (w_new_count),
        .o_nonempty (w_nonempty)
    );

    ldq_slot_ram #(.DEPTH(LEVELS * SLOTS), .AW(AW)) u_slots (
        .i_clk   (i_clk),
        .i_wr_en (w_slot_wr),
        .i_rd_en (w_slot_rd),
        .i_addr  (w_slot_addr),
        .i_wdata (r_handle),
        .o_rdata (w_slot_rdata)
    );

    // control
    assign w_load = ((r_state == S_READ) || (r_state == S_HOLD)) &&
                    (!r_out_valid || i_out_ready);
    assign w_acc  = i_in_valid && o_in_ready;

    always_comb begin
        n_state = r_state;
        unique case (r_state) inside
            S_IDLE: begin
                if (w_acc) n_state = S_LOOK;
            end
            S_LOOK: begin
                n_state = S_READ;
            end
            S_READ, S_HOLD: begin
                if (w_load) n_state = w_acc ? S_LOOK : S_IDLE;
                else        n_state = S_HOLD;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_in_ready = 1'b0;
        unique case (r_state) inside
            S_IDLE:         o_in_ready = 1'b1;
            S_LOOK:         o_in_ready = 1'b0;
            S_READ, S_HOLD: o_in_ready = w_load;
            default:        o_in_ready = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // level pick at transfer
    always_comb begin
        case (i_in.req_type)
            REQ_POST:  w_pick = LW'(i_in.target_level);
            REQ_TAKE:  w_pick = w_deep;
            REQ_STEAL: w_pick = w_shallow;
            default:   w_pick = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r_kind   <= i_in.req_type;
            r_handle <= i_in.task_handle;
            r_bad    <= ({1'b0, i_in.target_level} >= 9'(LEVELS));
            r_empty  <= !w_any;
            r_lvl    <= w_pick;
        end
    end

    // table update and slot access
    assign w_tail_sum = (HW+1)'(w_head) + (HW+1)'(w_count) - (HW+1)'(1);

    always_comb begin
        w_tab_wr    = 1'b0;
        w_slot_wr   = 1'b0;
        w_slot_rd   = 1'b0;
        w_pos       = w_head;
        w_new_head  = w_head;
        w_new_count = w_count;
        n_status    = ST_OK;
        n_lvl_res   = '0;
        n_pop       = 1'b0;
        if (r_state == S_LOOK) begin
            case (r_kind) inside
                REQ_POST: begin
                    if (r_bad) begin
                        n_status = ST_OUT_RANGE;
                    end else if (w_count >= CW'(SLOTS)) begin
                        n_status  = ST_FULL;
                        n_lvl_res = r_lvl;
                    end else begin
                        w_pos       = (w_head == '0) ? HW'(SLOTS - 1) : w_head - HW'(1);
                        w_new_head  = w_pos;
                        w_new_count = w_count + CW'(1);
                        w_tab_wr    = 1'b1;
                        w_slot_wr   = 1'b1;
                        n_lvl_res   = r_lvl;
                    end
                end
                REQ_TAKE, REQ_STEAL: begin
                    if (r_empty) begin
                        n_status = ST_EMPTY;
                    end else begin
                        if (r_kind == REQ_TAKE) begin
                            w_pos      = w_head;
                            w_new_head = (w_head == HW'(SLOTS - 1)) ? '0 : w_head + HW'(1);
                        end else begin
                            w_pos = (w_tail_sum >= (HW+1)'(SLOTS)) ?
                                    HW'(w_tail_sum - (HW+1)'(SLOTS)) : HW'(w_tail_sum);
                        end
                        w_new_count = w_count - CW'(1);
                        w_tab_wr    = 1'b1;
                        w_slot_rd   = 1'b1;
                        n_lvl_res   = r_lvl;
                        n_pop       = 1'b1;
                    end
                end
                default: begin
                    n_status = ST_OK;
                end
            endcase
        end
    end

    assign w_slot_addr = AW'(r_lvl) * AW'(SLOTS) + AW'(w_pos);

    always_ff @(posedge i_clk) begin
        if (r_state == S_LOOK) begin
            r_status  <= n_status;
            r_lvl_res <= n_lvl_res;
            r_pop     <= n_pop;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_out.status     <= r_status;
            r_out.handle_out <= r_pop ? w_slot_rdata : 16'd0;
            r_out.level_used <= 4'(r_lvl_res);
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

endmodule

[hdl/ldq_level_pick.sv]
// ----------------------------------------------------------------------------
// ldq_level_pick
// Priority pick of the deepest and the shallowest non-empty level.
// ----------------------------------------------------------------------------
module ldq_level_pick import ldq_pkg::*; #(
    parameter int LEVELS = LEVELS_DEF,
    parameter int LW     = $clog2(LEVELS)
) (
    input  logic [LEVELS-1:0] i_nonempty,
    output logic [LW-1:0]     o_deep,
    output logic [LW-1:0]     o_shallow,
    output logic              o_any
);

    always_comb begin
        o_deep = '0;
        for (int i = 0; i < LEVELS; i++) begin
            if (i_nonempty[i]) begin
                o_deep = LW'(i);
            end
        end
    end

    always_comb begin
        o_shallow = '0;
        for (int i = LEVELS - 1; i >= 0; i--) begin
            if (i_nonempty[i]) begin
                o_shallow = LW'(i);
            end
        end
    end

    assign o_any = |i_nonempty;

endmodule

[hdl/ldq_level_table.sv]
// ----------------------------------------------------------------------------
// ldq_level_table
// Per-level head and count memory with valid bits and non-empty flags.
// ----------------------------------------------------------------------------
module ldq_level_table import ldq_pkg::*; #(
    parameter int LEVELS = LEVELS_DEF,
    parameter int SLOTS  = SLOTS_DEF,
    parameter int LW     = $clog2(LEVELS),
    parameter int HW     = $clog2(SLOTS),
    parameter int CW     = $clog2(SLOTS + 1)
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_rd_en,
    input  logic [LW-1:0]     i_rd_addr,
    output logic [HW-1:0]     o_rd_head,
    output logic [CW-1:0]     o_rd_count,
    input  logic              i_wr_en,
    input  logic [LW-1:0]     i_wr_addr,
    input  logic [HW-1:0]     i_wr_head,
    input  logic [CW-1:0]     i_wr_count,
    output logic [LEVELS-1:0] o_nonempty
);

    logic [HW+CW-1:0] r_mem [LEVELS];
    logic [HW+CW-1:0] r_rdata;
    logic             r_rvalid;
    logic [LEVELS-1:0] r_valid;
    logic [LEVELS-1:0] r_nonempty;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= {i_wr_head, i_wr_count};
        end
        if (i_rd_en) begin
            r_rdata <= r_mem[i_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid    <= '0;
            r_nonempty <= '0;
            r_rvalid   <= 1'b0;
        end else begin
            if (i_wr_en) begin
                r_valid[i_wr_addr]    <= 1'b1;
                r_nonempty[i_wr_addr] <= (i_wr_count != '0);
            end
            if (i_rd_en) begin
                r_rvalid <= r_valid[i_rd_addr];
            end
        end
    end

    assign o_rd_head  = r_rvalid ? r_rdata[HW+CW-1:CW] : '0;
    assign o_rd_count = r_rvalid ? r_rdata[CW-1:0] : '0;
    assign o_nonempty = r_nonempty;

endmodule

[hdl/ldq_slot_ram.sv]
// ----------------------------------------------------------------------------
// ldq_slot_ram
// Single-port handle store, registered read.
// ----------------------------------------------------------------------------
module ldq_slot_ram import ldq_pkg::*; #(
    parameter int DEPTH = LEVELS_DEF * SLOTS_DEF,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic          i_clk,
    input  logic          i_wr_en,
    input  logic          i_rd_en,
    input  logic [AW-1:0] i_addr,
    input  logic [15:0]   i_wdata,
    output logic [15:0]   o_rdata
);

    logic [15:0] r_mem [DEPTH];
    logic [15:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_addr] <= i_wdata;
        end
        if (i_rd_en) begin
            r_rdata <= r_mem[i_addr];
        end
    end

    assign o_rdata = r_rdata;

endmodule
